FILE: design/grid_line_tile_walker_macros.svh
// Assertion macros for the grid line tile walker.
`ifndef GRID_LINE_TILE_WALKER_MACROS_SVH
`define GRID_LINE_TILE_WALKER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GLT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GLT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/glt_pkg.sv
// Package: sequencer state type and fixed widths of the grid line tile walker.
package glt_pkg;

    localparam int IDX_BITS = 16;
    localparam int PL_BITS = 17;
    localparam logic [IDX_BITS-1:0] LEN_LIMIT = 16'hFFFF;

    typedef enum logic [11:0] {
        S_IDLE = 12'b0000_0000_0001,
        S_DX   = 12'b0000_0000_0010,
        S_DY   = 12'b0000_0000_0100,
        S_GCD  = 12'b0000_0000_1000,
        S_GSH  = 12'b0000_0001_0000,
        S_LEN1 = 12'b0000_0010_0000,
        S_LEN2 = 12'b0000_0100_0000,
        S_TEST = 12'b0000_1000_0000,
        S_PREP = 12'b0001_0000_0000,
        S_WALK = 12'b0010_0000_0000,
        S_OUT  = 12'b0100_0000_0000
    } t_state;

endpackage

FILE: design/glt_in_if.sv
// Input channel: start and target tiles plus step index, valid/ready handshake.
interface glt_in_if #(
    parameter int COORD_BITS = 16
);
    import glt_pkg::*;

    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] target_x;
    logic signed [COORD_BITS-1:0] target_y;
    logic [IDX_BITS-1:0]          step_index;

    modport source (
        output valid, start_x, start_y, target_x, target_y, step_index,
        input  ready
    );
    modport sink (
        input  valid, start_x, start_y, target_x, target_y, step_index,
        output ready
    );
endinterface

FILE: design/glt_out_if.sv
// Output channel: reached tile, path length and ok flag, valid/ready handshake.
interface glt_out_if #(
    parameter int COORD_BITS = 16
);
    import glt_pkg::*;

    logic                         valid;
    logic                         ready;
    logic                         ok;
    logic signed [COORD_BITS-1:0] tile_x;
    logic signed [COORD_BITS-1:0] tile_y;
    logic [PL_BITS-1:0]           path_length;

    modport source (
        output valid, ok, tile_x, tile_y, path_length,
        input  ready
    );
    modport sink (
        input  valid, ok, tile_x, tile_y, path_length,
        output ready
    );
endinterface

FILE: design/grid_line_tile_walker.sv
// Grid line tile walker: one word in, one word out; a sequencer drives one shared
// add/subtract unit through distance, binary gcd, path length and the step walk.
// The gcd loop is skipped when an axis does not move, and the walk advances one
// tile step per cycle through the shared adder for step_index steps (up to
// 65535). A word is taken only while idle; the result is held on the output
// until it is taken.
module grid_line_tile_walker #(
    parameter int COORD_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    glt_in_if.sink    i_in,
    glt_out_if.source o_out
);
    import glt_pkg::*;

    `include "grid_line_tile_walker_macros.svh"

    localparam int C  = COORD_BITS;
    localparam int UW = C + 2;
    localparam int LW = C + 1;
    localparam int KW = (C > 1) ? $clog2(C) : 1;
    localparam int XW = PL_BITS + LW;

    t_state r_state, n_state;

    logic [C-1:0]        r_sx, n_sx, r_sy, n_sy, r_tx, n_tx, r_ty, n_ty;
    logic [IDX_BITS-1:0] r_idx, n_idx, r_cnt, n_cnt;
    logic [C-1:0]        r_dx, n_dx, r_dy, n_dy;
    logic                r_xs, n_xs, r_ys, n_ys;
    logic [C-1:0]        r_a, n_a, r_b, n_b;
    logic [KW-1:0]       r_k, n_k;
    logic                r_cm, n_cm, r_par, n_par, r_ok, n_ok;
    logic [LW-1:0]       r_len, n_len;
    logic [UW-1:0]       r_d, n_d, r_tie, n_tie;
    logic [C-1:0]        r_x, n_x, r_y, n_y;

    // shared add/subtract unit
    logic [UW-1:0] au_a, au_b, au_sum, au_neg;
    logic          au_sub;
    logic [C-1:0]  au_abs;
    logic          au_pos;

    logic          w_stepx, w_stepy, w_ok;
    logic [XW-1:0] w_lenx, w_idxx, w_lim;

    assign au_sum = au_sub ? (au_a - au_b) : (au_a + au_b);
    assign au_neg = '0 - au_sum;
    assign au_abs = au_sum[UW-1] ? au_neg[C-1:0] : au_sum[C-1:0];
    assign au_pos = !au_sum[UW-1] && (au_sum != '0);

    assign w_stepx = r_d[UW-1] || (r_d == '0);
    assign w_stepy = !r_d[UW-1];

    assign w_lenx = XW'(r_len);
    assign w_idxx = XW'(r_idx);
    assign w_lim  = XW'(LEN_LIMIT);
    assign w_ok   = (w_lenx <= w_lim) && (w_idxx <= w_lenx);

    always_comb begin
        au_a   = '0;
        au_b   = '0;
        au_sub = 1'b0;
        case (r_state)
            S_DX: begin
                au_a   = {{2{r_tx[C-1]}}, r_tx};
                au_b   = {{2{r_sx[C-1]}}, r_sx};
                au_sub = 1'b1;
            end
            S_DY: begin
                au_a   = {{2{r_ty[C-1]}}, r_ty};
                au_b   = {{2{r_sy[C-1]}}, r_sy};
                au_sub = 1'b1;
            end
            S_GCD: begin
                au_a   = {2'b00, r_a};
                au_b   = {2'b00, r_b};
                au_sub = 1'b1;
            end
            S_LEN1: begin
                au_a = {2'b00, r_dx};
                au_b = {2'b00, r_dy};
            end
            S_LEN2: begin
                au_a   = {1'b0, r_len};
                au_b   = {2'b00, r_a};
                au_sub = 1'b1;
            end
            S_PREP: begin
                au_a   = {2'b00, r_dy};
                au_b   = {2'b00, r_dx};
                au_sub = 1'b1;
            end
            S_WALK: begin
                au_a = r_d;
                if (w_stepx && w_stepy) begin
                    au_b = r_tie;
                end else if (w_stepx) begin
                    au_b = {1'b0, r_dy, 1'b0};
                end else begin
                    au_b   = {1'b0, r_dx, 1'b0};
                    au_sub = 1'b1;
                end
            end
            default: begin
                au_a   = '0;
                au_b   = '0;
                au_sub = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_sx  = r_sx;   n_sy  = r_sy;   n_tx = r_tx;   n_ty = r_ty;
        n_idx = r_idx;  n_cnt = r_cnt;
        n_dx  = r_dx;   n_dy  = r_dy;   n_xs = r_xs;   n_ys = r_ys;
        n_a   = r_a;    n_b   = r_b;    n_k  = r_k;
        n_cm  = r_cm;   n_par = r_par;  n_ok = r_ok;
        n_len = r_len;  n_d   = r_d;    n_tie = r_tie;
        n_x   = r_x;    n_y   = r_y;
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_sx    = i_in.start_x;
                    n_sy    = i_in.start_y;
                    n_tx    = i_in.target_x;
                    n_ty    = i_in.target_y;
                    n_idx   = i_in.step_index;
                    n_state = S_DX;
                end
            end
            S_DX: begin
                n_dx    = au_abs;
                n_xs    = au_pos;
                n_state = S_DY;
            end
            S_DY: begin
                n_dy  = au_abs;
                n_ys  = au_pos;
                n_a   = r_dx;
                n_b   = au_abs;
                n_k   = '0;
                n_cm  = 1'b1;
                n_par = 1'b0;
                if (r_dx == '0 || au_abs == '0) begin
                    n_state = S_LEN1;
                end else begin
                    n_state = S_GCD;
                end
            end
            S_GCD: begin
                if (r_cm) begin
                    // common factors of two; reduced values both odd iff parities match here
                    if (r_a[0] || r_b[0]) begin
                        n_par = r_a[0] && r_b[0];
                        n_cm  = 1'b0;
                    end else begin
                        n_a = r_a >> 1;
                        n_b = r_b >> 1;
                        n_k = r_k + KW'(1);
                    end
                end else if (r_a == r_b) begin
                    n_state = S_GSH;
                end else if (!r_a[0]) begin
                    n_a = r_a >> 1;
                end else if (!r_b[0]) begin
                    n_b = r_b >> 1;
                end else if (au_sum[UW-1]) begin
                    n_b = au_neg[C-1:0];
                end else begin
                    n_a = au_sum[C-1:0];
                end
            end
            S_GSH: begin
                if (r_k == '0) begin
                    n_state = S_LEN1;
                end else begin
                    n_a = r_a << 1;
                    n_k = r_k - KW'(1);
                end
            end
            S_LEN1: begin
                n_len   = au_sum[LW-1:0];
                n_state = S_LEN2;
            end
            S_LEN2: begin
                if (r_par) begin
                    n_len = au_sum[LW-1:0];
                end
                n_state = S_TEST;
            end
            S_TEST: begin
                n_ok = w_ok;
                if (w_ok) begin
                    n_state = S_PREP;
                end else begin
                    n_x     = '0;
                    n_y     = '0;
                    n_state = S_OUT;
                end
            end
            S_PREP: begin
                n_d     = au_sum;
                n_tie   = {au_sum[UW-2:0], 1'b0};
                n_cnt   = r_idx;
                n_x     = r_sx;
                n_y     = r_sy;
                n_state = S_WALK;
            end
            S_WALK: begin
                if (r_cnt == '0) begin
                    n_state = S_OUT;
                end else begin
                    n_d   = au_sum;
                    n_cnt = r_cnt - IDX_BITS'(1);
                    if (w_stepx) begin
                        n_x = r_xs ? (r_x + C'(1)) : (r_x - C'(1));
                    end
                    if (w_stepy) begin
                        n_y = r_ys ? (r_y + C'(1)) : (r_y - C'(1));
                    end
                end
            end
            S_OUT: begin
                if (o_out.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_sx  <= n_sx;   r_sy  <= n_sy;   r_tx <= n_tx;   r_ty <= n_ty;
        r_idx <= n_idx;  r_cnt <= n_cnt;
        r_dx  <= n_dx;   r_dy  <= n_dy;   r_xs <= n_xs;   r_ys <= n_ys;
        r_a   <= n_a;    r_b   <= n_b;    r_k  <= n_k;
        r_cm  <= n_cm;   r_par <= n_par;  r_ok <= n_ok;
        r_len <= n_len;  r_d   <= n_d;    r_tie <= n_tie;
        r_x   <= n_x;    r_y   <= n_y;
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = (r_state == S_OUT);
    assign o_out.ok          = r_ok;
    assign o_out.tile_x      = r_x;
    assign o_out.tile_y      = r_y;
    assign o_out.path_length = w_lenx[PL_BITS-1:0];

    `GLT_ASSERT_NOW(a_bad_zero, i_clk, i_rst_n, o_out.valid && !o_out.ok, (o_out.tile_x == '0) && (o_out.tile_y == '0), "rejected word carries nonzero tile")
    `GLT_ASSERT_NOW(a_ok_len, i_clk, i_rst_n, o_out.valid && o_out.ok, w_lenx <= w_lim, "ok word with path length over limit")
    `GLT_ASSERT_NXT(a_walk_cnt, i_clk, i_rst_n, (r_state == S_WALK) && (r_cnt != '0), r_cnt == $past(r_cnt) - IDX_BITS'(1), "walk counter did not step")
    `GLT_ASSERT_NOW(a_gcd_nz, i_clk, i_rst_n, r_state == S_GCD, (r_a != '0) && (r_b != '0), "gcd operand reached zero")
    `GLT_ASSERT_NOW(a_one_side, i_clk, i_rst_n, i_in.ready, !o_out.valid, "input taken while result pending")

endmodule
